// File: sv/trc_pkg.sv
// Shared types and constants of the reachability block.
// No dependencies; every other file uses it by scoped names.
package trc_pkg;

    localparam int NODES_DEF = 32;
    localparam int VTX_W     = 5;
    localparam int COUNT_W   = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_CLOSURE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [1:0] MODE_IGNORE   = 2'd0;
    localparam logic [1:0] MODE_DIRECTED = 2'd1;
    localparam logic [1:0] MODE_BOTH     = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_SWEEP
    } t_state;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // set the forward edge in the source row
        logic both;    // also set the reverse edge in the destination row
        logic copy;    // load closure row from adjacency row plus self-loop
        logic sweep;   // rotate closure rows one cell and apply the pivot
    } t_cell_ctl;

endpackage

// File: sv/trc_cmd_if.sv
// Command channel of the reachability block: valid/ready plus command beat.
// Depends on trc_pkg for field widths.
interface trc_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [trc_pkg::VTX_W-1:0] src;
    logic [trc_pkg::VTX_W-1:0] dst;
    logic [1:0]                mode;

    modport source (output valid, cmd, src, dst, mode, input ready);
    modport sink   (input valid, cmd, src, dst, mode, output ready);
endinterface

// File: sv/trc_res_if.sv
// Result channel of the reachability block: valid/ready plus result beat.
// Depends on trc_pkg for field widths.
interface trc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        reach_forward;
    logic                        reach_backward;
    logic [trc_pkg::COUNT_W-1:0] edge_total;

    modport source (output valid, reach_forward, reach_backward, edge_total, input ready);
    modport sink   (input valid, reach_forward, reach_backward, edge_total, output ready);
endinterface

// File: sv/trc_cell.sv
// One cell of the chain: holds one adjacency row and one closure row.
// Depends on trc_pkg (t_cell_ctl).
module trc_cell #(
    parameter int NODES = trc_pkg::NODES_DEF,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trc_pkg::t_cell_ctl  i_ctl,
    input  logic [NODES-1:0]    i_src_oh,
    input  logic [NODES-1:0]    i_dst_oh,
    input  logic [NODES-1:0]    i_piv_row,
    input  logic [NODES-1:0]    i_piv_mask,
    input  logic [NODES-1:0]    i_next_row,
    output logic [NODES-1:0]    o_row,
    output logic                o_fwd,
    output logic                o_bwd,
    output logic                o_new
);
    localparam logic [NODES-1:0] SelfOh = {{(NODES-1){1'b0}}, 1'b1} << IDX;

    logic [NODES-1:0] r_adj, n_adj;
    logic [NODES-1:0] r_clo, n_clo;
    logic             sel_src, sel_dst;

    assign sel_src = i_src_oh[IDX];
    assign sel_dst = i_dst_oh[IDX];

    always_comb begin
        n_adj = r_adj;
        if (i_ctl.insert && sel_src) begin
            n_adj = n_adj | i_dst_oh;
        end
        if (i_ctl.insert && i_ctl.both && sel_dst) begin
            n_adj = n_adj | i_src_oh;
        end
        n_clo = r_clo;
        if (i_ctl.copy) begin
            n_clo = r_adj | SelfOh;
        end else if (i_ctl.sweep) begin
            // take the neighbor's row; merge the pivot row if it reaches the pivot
            n_clo = i_next_row | ((|(i_next_row & i_piv_mask)) ? i_piv_row : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj <= '0;
            r_clo <= '0;
        end else begin
            r_adj <= n_adj;
            r_clo <= n_clo;
        end
    end

    assign o_row = r_clo;
    assign o_fwd = sel_src & (|(r_clo & i_dst_oh));
    assign o_bwd = sel_dst & (|(r_clo & i_src_oh));
    assign o_new = sel_src & ~(|(r_adj & i_dst_oh));
endmodule

// File: sv/transitive_closure_reachability.sv
// Every accepted command, of any kind, gets its registered result beat in the next cycle.
// Insert and query leave the block idle, so a new command can follow once the result
// slot is free or draining; a closure command keeps the block busy in ST_COPY, then in
// ST_SWEEP (one chain rotation per pivot vertex), during which no command is accepted.
// Reset (synchronous, active low) clears both matrices and the edge count.
module transitive_closure_reachability #(
    parameter int NODES = trc_pkg::NODES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    trc_cmd_if.sink   i_cmd,
    trc_res_if.source o_res
);
    trc_pkg::t_state             r_state, n_state;
    logic [NODES-1:0]            r_piv, n_piv;
    logic [trc_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                        r_ovalid;
    logic                        r_fwd, r_bwd;
    logic [trc_pkg::COUNT_W-1:0] r_total;

    trc_pkg::t_cell_ctl w_ctl;
    logic [NODES-1:0]   w_src_oh, w_dst_oh;
    logic [NODES-1:0]   w_row [NODES];
    logic [NODES-1:0]   w_fwd, w_bwd, w_new;
    logic               w_accept, w_insert;

    // Decode vertices to one-hot masks; a vertex at or above NODES gives all zeros,
    // so inserts and queries naming it fall away without a separate range check.
    always_comb begin
        for (int b = 0; b < NODES; b++) begin
            w_src_oh[b] = (32'(i_cmd.src) == 32'(b));
            w_dst_oh[b] = (32'(i_cmd.dst) == 32'(b));
        end
    end

    // Accept only when idle and the output slot is free or draining this cycle.
    assign i_cmd.ready = (r_state == trc_pkg::ST_IDLE) && (!r_ovalid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_insert = w_accept && (i_cmd.cmd == trc_pkg::CMD_INSERT)
                      && ((i_cmd.mode == trc_pkg::MODE_DIRECTED)
                          || (i_cmd.mode == trc_pkg::MODE_BOTH))
                      && (|w_src_oh) && (|w_dst_oh);

    always_comb begin
        w_ctl.insert = w_insert;
        w_ctl.both   = (i_cmd.mode == trc_pkg::MODE_BOTH);
        w_ctl.copy   = (r_state == trc_pkg::ST_COPY);
        w_ctl.sweep  = (r_state == trc_pkg::ST_SWEEP);
    end

    // Row j of the chain takes its next row from cell j+1; cell 0 holds the pivot row.
    for (genvar j = 0; j < NODES; j++) begin : g_cell
        trc_cell #(
            .NODES (NODES),
            .IDX   (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_src_oh   (w_src_oh),
            .i_dst_oh   (w_dst_oh),
            .i_piv_row  (w_row[0]),
            .i_piv_mask (r_piv),
            .i_next_row (w_row[(j + 1) % NODES]),
            .o_row      (w_row[j]),
            .o_fwd      (w_fwd[j]),
            .o_bwd      (w_bwd[j]),
            .o_new      (w_new[j])
        );
    end

    // Count a forward edge only when its entry was still clear; hold at the limit.
    always_comb begin
        n_cnt = r_cnt;
        if (w_insert && (|w_new) && (r_cnt != trc_pkg::COUNT_MAX)) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // Sequencer: copy adjacency into closure, then one pivot per rotation.
    always_comb begin
        n_state = r_state;
        n_piv   = r_piv;
        case (r_state)
            trc_pkg::ST_IDLE: begin
                if (w_accept && (i_cmd.cmd == trc_pkg::CMD_CLOSURE)) begin
                    n_state = trc_pkg::ST_COPY;
                end
            end
            trc_pkg::ST_COPY: begin
                n_state = trc_pkg::ST_SWEEP;
                n_piv   = {{(NODES-1){1'b0}}, 1'b1};
            end
            trc_pkg::ST_SWEEP: begin
                n_piv = {r_piv[NODES-2:0], 1'b0};
                if (r_piv[NODES-1]) begin
                    n_state = trc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= trc_pkg::ST_IDLE;
            r_piv    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_piv   <= n_piv;
            r_cnt   <= n_cnt;
            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result beat: reachability bits only on a query, count after this beat's insert.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd   <= (i_cmd.cmd == trc_pkg::CMD_QUERY) && (|w_fwd);
            r_bwd   <= (i_cmd.cmd == trc_pkg::CMD_QUERY) && (|w_bwd);
            r_total <= n_cnt;
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.reach_forward  = r_fwd;
    assign o_res.reach_backward = r_bwd;
    assign o_res.edge_total     = r_total;

`ifndef SYNTHESIS
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != trc_pkg::ST_IDLE) |-> !i_cmd.ready)
        else $error("command accepted during closure sweep");
    a_closure_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.cmd == trc_pkg::CMD_CLOSURE)) |=> (r_state == trc_pkg::ST_COPY))
        else $error("closure command did not start the copy");
    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_insert |=> (r_cnt == $past(r_cnt)))
        else $error("edge count moved without an insert");
    a_sweep_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == trc_pkg::ST_SWEEP) |-> $onehot(r_piv))
        else $error("pivot mask not one-hot during sweep");
`endif
endmodule
